/* src/hangul_jamo_glyph_composer_macros.svh */
// Assertion macros for the Hangul jamo glyph composer.
`ifndef HANGUL_JAMO_GLYPH_COMPOSER_MACROS_SVH
`define HANGUL_JAMO_GLYPH_COMPOSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HJG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hjg assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HJG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hjg assertion failed");

`endif

/* src/hjg_pkg.sv */
// Shared types, constants and jamo tables for the Hangul jamo glyph composer.
`timescale 1ns / 1ps

package hjg_pkg;

    localparam int KOREAN_GLYPHS   = 360;
    localparam int BYTES_PER_GLYPH = 32;
    localparam int STORE_BYTES     = KOREAN_GLYPHS * BYTES_PER_GLYPH;
    localparam int STORE_WORDS     = STORE_BYTES / 2;
    localparam int ROWS            = 16;

    localparam int MEDIAL_BASE_BYTES = 5120;
    localparam int MEDIAL_BYTES      = 2816;
    localparam int FINAL_BYTES       = 3584;
    localparam int FINAL_BASE_BYTES  = MEDIAL_BASE_BYTES + MEDIAL_BYTES;

    localparam int INI_PER_SET = 20;
    localparam int MED_PER_SET = 22;
    localparam int FIN_PER_SET = 28;

    localparam int GLYPH_W = $clog2(KOREAN_GLYPHS);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int WORD_AW = GLYPH_W + ROW_W;
    localparam int ADDR_W  = 14;
    localparam int CODE_W  = 5;

    localparam logic [GLYPH_W-1:0] MED_GLYPH_BASE =
        GLYPH_W'(MEDIAL_BASE_BYTES / BYTES_PER_GLYPH);
    localparam logic [GLYPH_W-1:0] FIN_GLYPH_BASE =
        GLYPH_W'(FINAL_BASE_BYTES / BYTES_PER_GLYPH);
    localparam logic [ADDR_W-1:0] STORE_LIMIT = ADDR_W'(STORE_BYTES);

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    localparam logic [1:0] PH_INI = 2'd0;
    localparam logic [1:0] PH_MED = 2'd1;
    localparam logic [1:0] PH_FIN = 2'd2;

    localparam logic [4:0] INITIAL_MAP [32] = '{
        5'd0,  5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd5,  5'd6,
        5'd7,  5'd8,  5'd9,  5'd10, 5'd11, 5'd12, 5'd13, 5'd14,
        5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd0,  5'd0,  5'd0,
        5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0};

    localparam logic [4:0] MEDIAL_MAP [32] = '{
        5'd0,  5'd0,  5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd5,
        5'd0,  5'd0,  5'd6,  5'd7,  5'd8,  5'd9,  5'd10, 5'd11,
        5'd0,  5'd0,  5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17,
        5'd0,  5'd0,  5'd18, 5'd19, 5'd20, 5'd21, 5'd0,  5'd0};

    localparam logic [4:0] FINAL_MAP [32] = '{
        5'd0,  5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd5,  5'd6,
        5'd7,  5'd8,  5'd9,  5'd10, 5'd11, 5'd12, 5'd13, 5'd14,
        5'd15, 5'd16, 5'd0,  5'd17, 5'd18, 5'd19, 5'd20, 5'd21,
        5'd22, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd0,  5'd0};

    localparam logic [2:0] INIT_SET_OPEN [22] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd3,
        3'd3, 3'd3, 3'd1, 3'd2, 3'd4, 3'd4, 3'd4, 3'd2, 3'd1, 3'd3, 3'd0};

    localparam logic [2:0] INIT_SET_CLOSED [22] = '{
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd7,
        3'd7, 3'd7, 3'd6, 3'd6, 3'd7, 3'd7, 3'd7, 3'd6, 3'd6, 3'd7, 3'd5};

    localparam logic [1:0] FINAL_SET [22] = '{
        2'd0, 2'd0, 2'd2, 2'd0, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd3, 2'd0,
        2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd1};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_FETCH,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr_req;

    typedef struct packed {
        logic              en;
        logic [WORD_AW-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic [CODE_W-1:0] ini;
        logic [CODE_W-1:0] med;
        logic [CODE_W-1:0] fin;
    } t_codes;

    typedef struct packed {
        logic [GLYPH_W-1:0] ini_glyph;
        logic [GLYPH_W-1:0] med_glyph;
        logic [GLYPH_W-1:0] fin_glyph;
        logic               ini_present;
        logic               med_present;
        logic               fin_present;
    } t_glyph_sel;

endpackage

/* src/hjg_if.sv */
// Request and row channel interfaces for the Hangul jamo glyph composer.
`timescale 1ns / 1ps

interface hjg_req_if;
    logic                      valid;
    logic                      ready;
    logic                      op;
    logic [hjg_pkg::ADDR_W-1:0] font_addr;
    logic [7:0]                font_data;
    logic [hjg_pkg::CODE_W-1:0] initial_code;
    logic [hjg_pkg::CODE_W-1:0] medial_code;
    logic [hjg_pkg::CODE_W-1:0] final_code;

    modport source (output valid, op, font_addr, font_data, initial_code, medial_code,
                    final_code, input ready);
    modport sink (input valid, op, font_addr, font_data, initial_code, medial_code,
                  final_code, output ready);
endinterface

interface hjg_row_if;
    logic                     valid;
    logic                     ready;
    logic [15:0]              row_bits;
    logic [hjg_pkg::ROW_W-1:0] row_index;
    logic                     last_row;

    modport source (output valid, row_bits, row_index, last_row, input ready);
    modport sink (input valid, row_bits, row_index, last_row, output ready);
endinterface

/* src/hjg_font_store.sv */
// Jamo font memory: byte writes, one 16-bit glyph row read per cycle.
`timescale 1ns / 1ps

module hjg_font_store (
    input  logic                         i_clk,
    input  hjg_pkg::t_wr_req             i_wr,
    input  hjg_pkg::t_rd_req             i_rd,
    output logic [15:0]                  o_rd_data
);

    logic [7:0]  r_mem_hi [hjg_pkg::STORE_WORDS];
    logic [7:0]  r_mem_lo [hjg_pkg::STORE_WORDS];
    logic [15:0] r_rd_data;
    logic [hjg_pkg::WORD_AW-1:0] wr_word;
    logic        wr_ok;

    assign wr_word = i_wr.addr[hjg_pkg::ADDR_W-1:1];
    assign wr_ok   = i_wr.en && (i_wr.addr < hjg_pkg::STORE_LIMIT);

    // The even byte of a row is its left half and lands in the high lane.
    always_ff @(posedge i_clk) begin
        if (wr_ok && !i_wr.addr[0]) begin
            r_mem_hi[wr_word] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok && i_wr.addr[0]) begin
            r_mem_lo[wr_word] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= {r_mem_hi[i_rd.addr], r_mem_lo[i_rd.addr]};
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/hjg_jamo_map.sv */
// Maps Johab codes to font glyph numbers through the jamo and set tables.
`timescale 1ns / 1ps

module hjg_jamo_map (
    input  hjg_pkg::t_codes     i_codes,
    output hjg_pkg::t_glyph_sel o_sel
);

    logic [4:0] ini;
    logic [4:0] med;
    logic [4:0] fin;
    logic [2:0] s1;
    logic [1:0] s2;
    logic [1:0] s3;

    always_comb begin
        ini = hjg_pkg::INITIAL_MAP[i_codes.ini];
        med = hjg_pkg::MEDIAL_MAP[i_codes.med];
        fin = hjg_pkg::FINAL_MAP[i_codes.fin];

        s1 = (fin != 5'd0) ? hjg_pkg::INIT_SET_CLOSED[med] : hjg_pkg::INIT_SET_OPEN[med];
        s2 = {(fin != 5'd0), !((ini == 5'd0) || (ini == 5'd1) || (ini == 5'd16))};
        s3 = hjg_pkg::FINAL_SET[med];

        o_sel.ini_glyph = hjg_pkg::GLYPH_W'(s1) * hjg_pkg::GLYPH_W'(hjg_pkg::INI_PER_SET)
                        + hjg_pkg::GLYPH_W'(ini);
        o_sel.med_glyph = hjg_pkg::MED_GLYPH_BASE
                        + hjg_pkg::GLYPH_W'(s2) * hjg_pkg::GLYPH_W'(hjg_pkg::MED_PER_SET)
                        + hjg_pkg::GLYPH_W'(med);
        o_sel.fin_glyph = hjg_pkg::FIN_GLYPH_BASE
                        + hjg_pkg::GLYPH_W'(s3) * hjg_pkg::GLYPH_W'(hjg_pkg::FIN_PER_SET)
                        + hjg_pkg::GLYPH_W'(fin);
        o_sel.ini_present = (ini != 5'd0);
        o_sel.med_present = (med != 5'd0);
        o_sel.fin_present = (fin != 5'd0);
    end

endmodule

/* src/hjg_row_seq.sv */
// Row sequencer: three font reads per row, ORed in one shared accumulator.
`timescale 1ns / 1ps

module hjg_row_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    hjg_req_if.sink             i_req,
    hjg_row_if.source           o_row,
    output hjg_pkg::t_codes     o_codes,
    input  hjg_pkg::t_glyph_sel i_sel,
    output hjg_pkg::t_wr_req    o_wr,
    output hjg_pkg::t_rd_req    o_rd,
    input  logic [15:0]         i_rd_data
);

    hjg_pkg::t_state     r_state;
    hjg_pkg::t_state     n_state;
    hjg_pkg::t_codes     r_codes;
    hjg_pkg::t_glyph_sel r_sel;
    logic [hjg_pkg::ROW_W-1:0] r_row;
    logic [1:0]          r_phase;
    logic                r_use;
    logic [15:0]         r_acc;

    logic                     accept;
    logic                     row_done;
    logic [hjg_pkg::GLYPH_W-1:0] sel_glyph;
    logic                     sel_present;

    assign accept   = i_req.valid && i_req.ready;
    assign row_done = o_row.valid && o_row.ready;

    always_comb begin
        case (r_phase)
            hjg_pkg::PH_INI: begin
                sel_glyph   = r_sel.ini_glyph;
                sel_present = r_sel.ini_present;
            end
            hjg_pkg::PH_MED: begin
                sel_glyph   = r_sel.med_glyph;
                sel_present = r_sel.med_present;
            end
            hjg_pkg::PH_FIN: begin
                sel_glyph   = r_sel.fin_glyph;
                sel_present = r_sel.fin_present;
            end
            default: begin
                sel_glyph   = r_sel.ini_glyph;
                sel_present = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            hjg_pkg::ST_IDLE: begin
                if (accept && (i_req.op == hjg_pkg::OP_RENDER)) begin
                    n_state = hjg_pkg::ST_SETUP;
                end
            end
            hjg_pkg::ST_SETUP: begin
                n_state = hjg_pkg::ST_FETCH;
            end
            hjg_pkg::ST_FETCH: begin
                if (r_phase == hjg_pkg::PH_FIN) begin
                    n_state = hjg_pkg::ST_DRAIN;
                end
            end
            hjg_pkg::ST_DRAIN: begin
                n_state = hjg_pkg::ST_EMIT;
            end
            hjg_pkg::ST_EMIT: begin
                if (row_done) begin
                    n_state = o_row.last_row ? hjg_pkg::ST_IDLE : hjg_pkg::ST_FETCH;
                end
            end
            default: begin
                n_state = hjg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        i_req.ready      = (r_state == hjg_pkg::ST_IDLE);
        o_row.valid      = (r_state == hjg_pkg::ST_EMIT);
        o_row.row_bits   = r_acc;
        o_row.row_index  = r_row;
        o_row.last_row   = (r_row == hjg_pkg::ROW_W'(hjg_pkg::ROWS - 1));
        o_rd.en          = (r_state == hjg_pkg::ST_FETCH);
        o_rd.addr        = {sel_glyph, r_row};
        o_wr.en          = accept && (i_req.op == hjg_pkg::OP_WRITE);
        o_wr.addr        = i_req.font_addr;
        o_wr.data        = i_req.font_data;
        o_codes          = r_codes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hjg_pkg::ST_IDLE;
            r_phase <= 2'd0;
            r_use   <= 1'b0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= (r_state == hjg_pkg::ST_FETCH) ? r_phase + 2'd1 : 2'd0;
            r_use   <= (r_state == hjg_pkg::ST_FETCH) && sel_present;
            if (r_state == hjg_pkg::ST_SETUP) begin
                r_row <= '0;
            end else if (row_done) begin
                r_row <= r_row + hjg_pkg::ROW_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_codes.ini <= i_req.initial_code;
            r_codes.med <= i_req.medial_code;
            r_codes.fin <= i_req.final_code;
        end
        if (r_state == hjg_pkg::ST_SETUP) begin
            r_sel <= i_sel;
        end
        if ((r_state == hjg_pkg::ST_SETUP) || row_done) begin
            r_acc <= '0;
        end else if (r_use) begin
            r_acc <= r_acc | i_rd_data;
        end
    end

endmodule

/* src/hangul_jamo_glyph_composer.sv */
// An accepted render request passes through a setup state; each row then takes three
// font memory reads through its single read port, a drain state for the last read data
// and an emit state, so a render holds the block until its last row is taken; a write
// request is taken while idle and leaves the block idle.
// Reset clears the sequencer only; font memory contents are undefined until written.
`timescale 1ns / 1ps
`include "hangul_jamo_glyph_composer_macros.svh"

module hangul_jamo_glyph_composer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hjg_req_if.sink   i_in,
    hjg_row_if.source o_out
);

    hjg_pkg::t_codes     codes;
    hjg_pkg::t_glyph_sel sel;
    hjg_pkg::t_wr_req    wr;
    hjg_pkg::t_rd_req    rd;
    logic [15:0]         rd_data;

    hjg_row_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_in),
        .o_row     (o_out),
        .o_codes   (codes),
        .i_sel     (sel),
        .o_wr      (wr),
        .o_rd      (rd),
        .i_rd_data (rd_data)
    );

    hjg_jamo_map u_map (
        .i_codes (codes),
        .o_sel   (sel)
    );

    hjg_font_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd      (rd),
        .o_rd_data (rd_data)
    );

    `HJG_ASSERT_NEXT(a_render_busy, i_clk, i_rst_n, i_in.valid && i_in.ready && (i_in.op == hjg_pkg::OP_RENDER), !i_in.ready)
    `HJG_ASSERT_NEXT(a_mid_row_busy, i_clk, i_rst_n, o_out.valid && o_out.ready && !o_out.last_row, !i_in.ready && !o_out.valid)
    `HJG_ASSERT_NEXT(a_last_row_idle, i_clk, i_rst_n, o_out.valid && o_out.ready && o_out.last_row, i_in.ready && !o_out.valid)
    `HJG_ASSERT_NOW(a_no_read_on_write, i_clk, i_rst_n, wr.en, !rd.en && !o_out.valid)

endmodule
